@@ hdl/glos_pkg.sv @@
package glos_pkg;

    // Build defaults for the storage parameters
    localparam int DEF_MAX_CELLS = 4096;
    localparam int DEF_MAX_STEPS = 1024;

    // Field widths
    localparam int DIM_W      = 13;
    localparam int CS_W       = 16;
    localparam int COORD_W    = 24;
    localparam int CIDX_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream word layout
    localparam int S_DATA_W = 120;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 8;
    localparam int OFF_CIDX = 0;
    localparam int OFF_BYTE = 12;
    localparam int OFF_SX   = 20;
    localparam int OFF_SZ   = 44;
    localparam int OFF_EX   = 68;
    localparam int OFF_EZ   = 92;

    // Datapath widths
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 18;
    localparam int ROOT_N     = 25;
    localparam int RAD_W      = 2 * ROOT_N;
    localparam int ROOT_REM_W = ROOT_N + 1;
    localparam int IDX_W      = 2 * DIM_W + 1;
    localparam int PROD_W     = DIM_W + CS_W;

    // Commands carried in tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 2'd2;

    localparam logic [DIM_W-1:0] RST_GRID_DIM  = 13'd64;
    localparam logic [CS_W-1:0]  RST_CELL_SIZE = 16'd256;

    typedef logic [2:0] div_sel_t;

    // Division jobs, in the order the controller runs them
    localparam div_sel_t DV_STEPS = 3'd0;
    localparam div_sel_t DV_QX    = 3'd1;
    localparam div_sel_t DV_QZ    = 3'd2;
    localparam div_sel_t DV_CQX   = 3'd3;
    localparam div_sel_t DV_CQZ   = 3'd4;
    localparam div_sel_t DV_CX    = 3'd5;
    localparam div_sel_t DV_CZ    = 3'd6;

    typedef struct packed {
        logic     clr_step;
        logic     load_we;
        logic     q_capture;
        logic     sub_go;
        logic     sq_go;
        logic     root_init;
        logic     root_step;
        logic     div_start;
        div_sel_t div_sel;
        logic     samp_addr;
        logic     samp_test;
        logic     out_push;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic coincident;
        logic root_last;
        logic div_done;
        logic samp_stop;
        logic out_free;
    } dp_sts_t;

endpackage

@@ hdl/glos_div.sv @@
module glos_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [glos_pkg::NUM_W-1:0]   num,
    input  logic        [glos_pkg::DEN_W-1:0]   den,
    output logic                                done,
    output logic signed [glos_pkg::NUM_W-1:0]   quo,
    output logic        [glos_pkg::DEN_W-1:0]   rem
);
    import glos_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic                    busy_reg, busy_next;
    logic                    fix_reg, fix_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic [NUM_W-1:0]        q_reg, q_next;
    logic [DEN_W-1:0]        r_reg, r_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic signed [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DEN_W:0]          r_sh;
    logic                    ge;

    // Restoring divide on the magnitude, one bit a cycle, then a floor fix-up
    always_comb begin
        busy_next = busy_reg;
        fix_next  = fix_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        r_sh      = {r_reg, q_reg[NUM_W-1]};
        ge        = (r_sh >= {1'b0, den_reg});
        if (start) begin
            busy_next = 1'b1;
            fix_next  = 1'b0;
            cnt_next  = '0;
            neg_next  = num[NUM_W-1];
            q_next    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            r_next    = '0;
            den_next  = den;
        end else if (busy_reg) begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            r_next   = ge ? DEN_W'(r_sh - {1'b0, den_reg}) : r_sh[DEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end else if (fix_reg) begin
            fix_next  = 1'b0;
            done_next = 1'b1;
            if (neg_reg && (r_reg != '0)) begin
                quo_next = $signed(~q_reg);
                rem_next = den_reg - r_reg;
            end else if (neg_reg) begin
                quo_next = $signed(-q_reg);
                rem_next = r_reg;
            end else begin
                quo_next = $signed(q_reg);
                rem_next = r_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

@@ hdl/glos_dp.sv @@
module glos_dp #(
    parameter int MAX_CELLS = glos_pkg::DEF_MAX_CELLS,
    parameter int MAX_STEPS = glos_pkg::DEF_MAX_STEPS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  glos_pkg::dp_cmd_t                   cmd,
    output glos_pkg::dp_sts_t                   sts,
    input  logic [glos_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                cfg_valid,
    input  logic [glos_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glos_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [glos_pkg::M_DATA_W-1:0]       m_tdata
);
    import glos_pkg::*;

    localparam int AW     = $clog2(MAX_CELLS);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int RCNT_W = $clog2(ROOT_N);
    localparam int SQ_W   = 2 * COORD_W;

    // Configuration
    logic [DIM_W-1:0] gw_reg, gh_reg;
    logic [CS_W-1:0]  cs_reg;
    logic [CS_W-1:0]  cs_eff;
    logic [CS_W:0]    cs2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= RST_GRID_DIM;
            gh_reg <= RST_GRID_DIM;
            cs_reg <= RST_CELL_SIZE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_WIDTH:  gw_reg <= cfg_data[DIM_W-1:0];
                REG_GRID_HEIGHT: gh_reg <= cfg_data[DIM_W-1:0];
                REG_CELL_SIZE:   cs_reg <= cfg_data[CS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cs_eff = (cs_reg == '0) ? CS_W'(1) : cs_reg;
    assign cs2    = {cs_eff, 1'b0};

    // Query capture and setup
    logic signed [COORD_W-1:0] ax_reg, az_reg, bx_reg, bz_reg;
    logic signed [COORD_W:0]   dx_reg, dz_reg, dx_c, dz_c;
    logic [COORD_W-1:0]        adx_reg, adz_reg;
    logic [PROD_W-1:0]         wcs_reg, hcs_reg;
    logic [SQ_W-1:0]           sqx_reg, sqz_reg;

    assign dx_c = {bx_reg[COORD_W-1], bx_reg} - {ax_reg[COORD_W-1], ax_reg};
    assign dz_c = {bz_reg[COORD_W-1], bz_reg} - {az_reg[COORD_W-1], az_reg};

    always_ff @(posedge aclk) begin
        if (cmd.q_capture) begin
            ax_reg <= s_tdata[OFF_SX +: COORD_W];
            az_reg <= s_tdata[OFF_SZ +: COORD_W];
            bx_reg <= s_tdata[OFF_EX +: COORD_W];
            bz_reg <= s_tdata[OFF_EZ +: COORD_W];
        end
        if (cmd.sub_go) begin
            dx_reg  <= dx_c;
            dz_reg  <= dz_c;
            adx_reg <= dx_c[COORD_W] ? COORD_W'(-dx_c) : dx_c[COORD_W-1:0];
            adz_reg <= dz_c[COORD_W] ? COORD_W'(-dz_c) : dz_c[COORD_W-1:0];
            wcs_reg <= PROD_W'(gw_reg) * PROD_W'(cs_eff);
            hcs_reg <= PROD_W'(gh_reg) * PROD_W'(cs_eff);
        end
        if (cmd.sq_go) begin
            sqx_reg <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
            sqz_reg <= SQ_W'(adz_reg) * SQ_W'(adz_reg);
        end
    end

    // Integer square root, two radicand bits a cycle
    logic [RAD_W-1:0]      rad_reg;
    logic [ROOT_REM_W-1:0] rrem_reg;
    logic [ROOT_N-1:0]     root_reg;
    logic [RCNT_W-1:0]     rcnt_reg;
    logic [ROOT_REM_W+1:0] rsh, rtrial;
    logic                  rge;

    assign rsh    = {rrem_reg, rad_reg[RAD_W-1 -: 2]};
    assign rtrial = (ROOT_REM_W+2)'({root_reg, 2'b01});
    assign rge    = (rsh >= rtrial);

    always_ff @(posedge aclk) begin
        if (cmd.root_init) begin
            rad_reg  <= RAD_W'(sqx_reg) + RAD_W'(sqz_reg);
            rrem_reg <= '0;
            root_reg <= '0;
            rcnt_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rrem_reg <= rge ? ROOT_REM_W'(rsh - rtrial) : ROOT_REM_W'(rsh);
            root_reg <= {root_reg[ROOT_N-2:0], rge};
            rcnt_reg <= rcnt_reg + RCNT_W'(1);
        end
    end

    // Shared divider
    logic signed [NUM_W-1:0] div_num, div_quo;
    logic [DEN_W-1:0]        div_den, div_rem;
    logic                    div_done;
    logic [NUM_W-1:0]        five_dist;
    logic [STEP_W-1:0]       steps_reg;
    logic                    clamped_reg;
    logic signed [NUM_W-1:0] qx_reg, qz_reg, cqx_reg, cqz_reg;
    logic [DEN_W-1:0]        rx_reg, rz_reg, crx_reg, crz_reg;

    assign five_dist = NUM_W'({root_reg, 2'b00}) + NUM_W'(root_reg);

    always_comb begin
        case (cmd.div_sel)
            DV_STEPS: begin
                div_num = $signed(five_dist);
                div_den = DEN_W'(cs2);
            end
            DV_QX: begin
                div_num = NUM_W'(dx_reg);
                div_den = DEN_W'(steps_reg);
            end
            DV_QZ: begin
                div_num = NUM_W'(dz_reg);
                div_den = DEN_W'(steps_reg);
            end
            DV_CQX: begin
                div_num = qx_reg;
                div_den = DEN_W'(cs_eff);
            end
            DV_CQZ: begin
                div_num = qz_reg;
                div_den = DEN_W'(cs_eff);
            end
            DV_CX: begin
                div_num = $signed(NUM_W'(ax_reg) + NUM_W'(ax_reg) + NUM_W'(wcs_reg));
                div_den = DEN_W'(cs2);
            end
            DV_CZ: begin
                div_num = $signed(NUM_W'(az_reg) + NUM_W'(az_reg) + NUM_W'(hcs_reg));
                div_den = DEN_W'(cs2);
            end
            default: begin
                div_num = '0;
                div_den = '1;
            end
        endcase
    end

    glos_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // Sample walk: cell and remainder per axis, stepped by exact increments
    logic signed [NUM_W-1:0] gx_reg, gz_reg, gx_next, gz_next;
    logic [DEN_W-1:0]        mx_reg, mz_reg, mx_next, mz_next;
    logic [DEN_W-1:0]        rxa_reg, rza_reg, rxa_next, rza_next;
    logic [STEP_W-1:0]       cnt_reg;
    logic [DEN_W:0]          rxs, rzs;
    logic [DEN_W+1:0]        mxs, mzs;
    logic                    cx_carry, cz_carry, mx_wrap, mz_wrap;
    logic                    big_q;
    logic                    samp_bad, samp_last, samp_stop;

    assign big_q = ($unsigned(div_quo) >= NUM_W'(MAX_STEPS));

    always_comb begin
        rxs      = (DEN_W+1)'(rxa_reg) + (DEN_W+1)'(rx_reg);
        cx_carry = (rxs >= (DEN_W+1)'(steps_reg));
        rxa_next = cx_carry ? DEN_W'(rxs - (DEN_W+1)'(steps_reg)) : DEN_W'(rxs);
        mxs      = (DEN_W+2)'(mx_reg) + (DEN_W+2)'({crx_reg, 1'b0})
                   + (DEN_W+2)'({cx_carry, 1'b0});
        mx_wrap  = (mxs >= (DEN_W+2)'(cs2));
        mx_next  = mx_wrap ? DEN_W'(mxs - (DEN_W+2)'(cs2)) : DEN_W'(mxs);
        gx_next  = $signed(gx_reg + cqx_reg + NUM_W'(mx_wrap));

        rzs      = (DEN_W+1)'(rza_reg) + (DEN_W+1)'(rz_reg);
        cz_carry = (rzs >= (DEN_W+1)'(steps_reg));
        rza_next = cz_carry ? DEN_W'(rzs - (DEN_W+1)'(steps_reg)) : DEN_W'(rzs);
        mzs      = (DEN_W+2)'(mz_reg) + (DEN_W+2)'({crz_reg, 1'b0})
                   + (DEN_W+2)'({cz_carry, 1'b0});
        mz_wrap  = (mzs >= (DEN_W+2)'(cs2));
        mz_next  = mz_wrap ? DEN_W'(mzs - (DEN_W+2)'(cs2)) : DEN_W'(mzs);
        gz_next  = $signed(gz_reg + cqz_reg + NUM_W'(mz_wrap));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg   <= '0;
            clamped_reg <= 1'b0;
        end else if (cmd.sq_go) begin
            steps_reg   <= '0;
            clamped_reg <= 1'b0;
        end else if (div_done && (cmd.div_sel == DV_STEPS)) begin
            clamped_reg <= big_q;
            steps_reg   <= big_q ? STEP_W'(MAX_STEPS) : STEP_W'(div_quo + 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (div_done) begin
            case (cmd.div_sel)
                DV_QX: begin
                    qx_reg <= div_quo;
                    rx_reg <= div_rem;
                end
                DV_QZ: begin
                    qz_reg <= div_quo;
                    rz_reg <= div_rem;
                end
                DV_CQX: begin
                    cqx_reg <= div_quo;
                    crx_reg <= div_rem;
                end
                DV_CQZ: begin
                    cqz_reg <= div_quo;
                    crz_reg <= div_rem;
                end
                default: ;
            endcase
        end
        if (cmd.sq_go) begin
            rxa_reg <= '0;
            rza_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.samp_test && !samp_stop) begin
            rxa_reg <= rxa_next;
            rza_reg <= rza_next;
            cnt_reg <= cnt_reg + STEP_W'(1);
        end
        if (div_done && (cmd.div_sel == DV_CX)) begin
            gx_reg <= div_quo;
            mx_reg <= div_rem;
        end else if (cmd.samp_test && !samp_stop) begin
            gx_reg <= gx_next;
            mx_reg <= mx_next;
        end
        if (div_done && (cmd.div_sel == DV_CZ)) begin
            gz_reg <= div_quo;
            mz_reg <= div_rem;
        end else if (cmd.samp_test && !samp_stop) begin
            gz_reg <= gz_next;
            mz_reg <= mz_next;
        end
    end

    // Map lookup
    logic [IDX_W-1:0] idx_c;
    logic             gx_in, gz_in;
    logic             ok_reg, rd_reg, hit_reg;
    logic [AW-1:0]    addr_reg, clr_reg;
    logic             mem [MAX_CELLS];
    logic             load_ok;

    assign gx_in   = !gx_reg[NUM_W-1] && ($unsigned(gx_reg) < NUM_W'(gw_reg));
    assign gz_in   = !gz_reg[NUM_W-1] && ($unsigned(gz_reg) < NUM_W'(gh_reg));
    assign idx_c   = IDX_W'(gx_reg[DIM_W-1:0]) * IDX_W'(gh_reg) + IDX_W'(gz_reg[DIM_W-1:0]);
    assign load_ok = cmd.load_we && (32'(s_tdata[OFF_CIDX +: CIDX_W]) < 32'(MAX_CELLS));

    always_ff @(posedge aclk) begin
        if (cmd.samp_addr) begin
            ok_reg   <= gx_in && gz_in && (idx_c < IDX_W'(MAX_CELLS));
            addr_reg <= AW'(idx_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[clr_reg] <= 1'b0;
        end else if (load_ok) begin
            mem[AW'(s_tdata[OFF_CIDX +: CIDX_W])] <= (s_tdata[OFF_BYTE +: BYTE_W] == '0);
        end
        rd_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + AW'(1);
        end
    end

    assign samp_bad  = !ok_reg || !rd_reg;
    assign samp_last = (cnt_reg == steps_reg);
    assign samp_stop = samp_bad || samp_last;

    always_ff @(posedge aclk) begin
        if (cmd.samp_test) begin
            hit_reg <= samp_bad;
        end
    end

    // Result register
    logic       ov_reg;
    logic [1:0] od_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.out_push) begin
            ov_reg <= 1'b1;
        end else if (m_tready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_push) begin
            od_reg <= {clamped_reg, hit_reg};
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = M_DATA_W'(od_reg);

    assign sts.clr_last   = (clr_reg == AW'(MAX_CELLS - 1));
    assign sts.coincident = (dx_reg == '0) && (dz_reg == '0);
    assign sts.root_last  = (rcnt_reg == RCNT_W'(ROOT_N - 1));
    assign sts.div_done   = div_done;
    assign sts.samp_stop  = samp_stop;
    assign sts.out_free   = !ov_reg || m_tready;

`ifndef ASSERT_OFF
    a_clamp_max: assert property (@(posedge aclk) disable iff (!aresetn)
        clamped_reg |-> (steps_reg == STEP_W'(MAX_STEPS)))
        else $error("clamped query with step count below the limit");
`endif
`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word dropped or changed while stalled");
`endif
`ifndef ASSERT_OFF
    a_samp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.samp_test |-> (cnt_reg <= steps_reg))
        else $error("sample count ran past the step count");
`endif

endmodule

@@ hdl/glos_ctrl.sv @@
module glos_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic [glos_pkg::S_USER_W-1:0] s_tuser,
    output logic                          s_tready,
    output glos_pkg::dp_cmd_t             cmd,
    input  glos_pkg::dp_sts_t             sts
);
    import glos_pkg::*;

    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_SUB       = 4'd2;
    localparam logic [3:0] ST_SQ        = 4'd3;
    localparam logic [3:0] ST_ROOT_INIT = 4'd4;
    localparam logic [3:0] ST_ROOT      = 4'd5;
    localparam logic [3:0] ST_DIV_START = 4'd6;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd7;
    localparam logic [3:0] ST_SAMP_A    = 4'd8;
    localparam logic [3:0] ST_SAMP_R    = 4'd9;
    localparam logic [3:0] ST_SAMP_T    = 4'd10;
    localparam logic [3:0] ST_DONE      = 4'd11;

    logic [3:0] state_reg, state_next;
    div_sel_t   sel_reg, sel_next;

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0] == CMD_QUERY) begin
                        cmd.q_capture = 1'b1;
                        state_next    = ST_SUB;
                    end else begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_SUB: begin
                cmd.sub_go = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.sq_go = 1'b1;
                if (sts.coincident) begin
                    sel_next   = DV_CX;
                    state_next = ST_DIV_START;
                end else begin
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT: begin
                cmd.root_init = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (sts.root_last) begin
                    sel_next   = DV_STEPS;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_DIV_START;
                    case (sel_reg)
                        DV_STEPS: sel_next = DV_QX;
                        DV_QX:    sel_next = DV_QZ;
                        DV_QZ:    sel_next = DV_CQX;
                        DV_CQX:   sel_next = DV_CQZ;
                        DV_CQZ:   sel_next = DV_CX;
                        DV_CX:    sel_next = DV_CZ;
                        default:  state_next = ST_SAMP_A;
                    endcase
                end
            end
            ST_SAMP_A: begin
                cmd.samp_addr = 1'b1;
                state_next    = ST_SAMP_R;
            end
            ST_SAMP_R: begin
                state_next = ST_SAMP_T;
            end
            ST_SAMP_T: begin
                cmd.samp_test = 1'b1;
                state_next    = sts.samp_stop ? ST_DONE : ST_SAMP_A;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_push = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            sel_reg   <= DV_STEPS;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

`ifndef ASSERT_OFF
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");
`endif
`ifndef ASSERT_OFF
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_push |-> sts.out_free)
        else $error("result pushed over an unread result");
`endif
`ifndef ASSERT_OFF
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_step, cmd.load_we, cmd.q_capture, cmd.div_start, cmd.samp_test}))
        else $error("conflicting datapath commands");
`endif

endmodule

@@ hdl/grid_line_of_sight_test_unit.sv @@
// Occupancy-grid line-of-sight unit.
// Input stream (s_*): tuser[0] is the command, 0 = load one map cell, 1 = line query.
//   Loads write their cell and produce no result word. Queries produce one result word.
// Result stream (m_*): tdata[0] = hit, tdata[1] = step count was clamped.
// Config channel (cfg_*): index 0 grid width, 1 grid height, 2 cell size (Q8.8);
//   always ready, write only while no query is in flight.
// Query work: samples = steps + 1 at most, fewer when a blocked sample ends the walk
//   early; coincident ends run two divides and one sample. The work is done by one
//   shared bit-serial divider (seven divides), a square root, and an address/read/test
//   loop per sample.
// One item is worked at a time; s_tready is high only when the unit is idle.
// Reset: synchronous, active low. After reset a clearing pass writes every map
//   entry to wall with s_tready low; config writes still land.
// Stall: the result sits in an output register; the next item is accepted while
//   it waits, and a later query only holds at its end until the register is free.
module grid_line_of_sight_test_unit #(
    parameter int MAX_CELLS = glos_pkg::DEF_MAX_CELLS,
    parameter int MAX_STEPS = glos_pkg::DEF_MAX_STEPS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata, from bit 0: cell_index[11:0], cell_byte[19:12], start_x[43:20],
    //   start_z[67:44], end_x[91:68], end_z[115:92], zero pad[119:116]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [glos_pkg::S_DATA_W-1:0]     s_tdata,
    // s_tuser: command[0]
    input  logic [glos_pkg::S_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: hit[0], steps_clamped[1], zero pad[7:2]
    output logic [glos_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [glos_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [glos_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import glos_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    glos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    glos_dp #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
